FILE: rtl/apvr_pkg.sv
// Shared types, widths and constants for the angle PID velocity regulator.
// No dependencies; imported by every module of the block.
// Holds the fixed-point scaling, the controller/datapath command types and config codes.
package apvr_pkg;

  // Fixed-point scaling of angles, error, integral and velocity
  localparam int FRAC_BITS = 16;

  // Field and state widths
  localparam int ANG_W       = 24;               // angle / gain register width
  localparam int STEP_W      = 10;               // step_ms width
  localparam int RAW_W       = ANG_W + 1;        // raw setpoint - angle difference
  localparam int ERR_W       = 19;               // wrapped error, within +/-pi
  localparam int EP_W        = ERR_W + STEP_W + 1;
  localparam int INTEG_W     = 40;               // error integral
  localparam int INTEG_SPLIT = 20;               // low half of integral for split multiply
  localparam int VEL_W       = 21;               // output velocity
  localparam int CFG_IDX_W   = 3;

  // Divider geometry
  localparam int NUM_W      = 32;
  localparam int DEN_W      = STEP_W + 1;
  localparam int DIV_BITS   = 30;
  localparam int QUO_W      = DIV_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS + 1);

  // Integral scaling: floor(n / 2000) as floor(n / 16), then a reciprocal multiply by
  // ceil(2^32 / 125); exact for magnitudes below 2^25
  localparam int IDIV_PRE    = 4;
  localparam int IDIV_ODD    = 125;
  localparam int IDIV_SH     = 32;
  localparam int IDIV_MAG_W  = 25;
  localparam int IDIV_RCP_W  = 26;
  localparam int IDIV_PROD_W = IDIV_MAG_W + IDIV_RCP_W;
  localparam logic [IDIV_RCP_W-1:0] IDIV_RECIP = 26'd34359739;

  // Multiplier / accumulator
  localparam int MUL_A_W = ANG_W + 1;
  localparam int MUL_B_W = QUO_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 52;

  // Wrap reduction: remainder steps against 2*pi << 5 .. 2*pi << 0
  localparam int WRAP_STEPS = 6;
  localparam int WRAP_IDX_W = $clog2(WRAP_STEPS);

  localparam int MS_PER_S = 1000;

  localparam longint PI_Q32 = 64'sd13493037705;
  localparam longint PI_QL  = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam logic signed [RAW_W-1:0] PI_R     = RAW_W'(PI_QL);
  localparam logic [ANG_W-1:0]        TWO_PI_U = ANG_W'(2 * PI_QL);
  localparam logic signed [ACC_W-1:0] LIMIT    = ACC_W'(longint'(10) <<< FRAC_BITS);

  // Register reset values
  localparam logic [ANG_W-1:0]  RST_KP   = 24'd983040;
  localparam logic [ANG_W-1:0]  RST_KI   = 24'd0;
  localparam logic [ANG_W-1:0]  RST_KD   = 24'd32768;
  localparam logic [ANG_W-1:0]  RST_TGT  = 24'd0;
  localparam logic [STEP_W-1:0] RST_STEP = 10'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_TGT  = 3'd3,
    REG_STEP = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ANG_W-1:0]        kp;
    logic [ANG_W-1:0]        ki;
    logic [ANG_W-1:0]        kd;
    logic signed [ANG_W-1:0] tgt;
    logic [STEP_W-1:0]       step;
  } cfg_t;

  typedef enum logic [1:0] {
    MS_P  = 2'd0,
    MS_D  = 2'd1,
    MS_IL = 2'd2,
    MS_IH = 2'd3
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_WINIT  = 4'd1,
    ST_WSTEP  = 4'd2,
    ST_WFIN   = 4'd3,
    ST_PREP   = 4'd4,
    ST_DSTART = 4'd5,
    ST_DWAIT  = 4'd6,
    ST_MP     = 4'd7,
    ST_MD     = 4'd8,
    ST_MIL    = 4'd9,
    ST_MIH    = 4'd10,
    ST_MACC   = 4'd11,
    ST_FIN    = 4'd12
  } state_t;

  typedef struct packed {
    logic                  load_err;
    logic                  wrap_init;
    logic                  wrap_step;
    logic [WRAP_IDX_W-1:0] wrap_idx;
    logic                  wrap_fin;
    logic                  prep;
    logic                  div_start;
    logic                  integ_upd;
    logic                  mul_en;
    mul_sel_t              mul_sel;
    logic                  acc_clr;
    logic                  acc_en;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

FILE: rtl/apvr_div.sv
// Iterative signed-by-unsigned divider, floor rounding, one quotient bit per cycle.
// Depends on apvr_pkg for widths.
// Busy from start until the quotient is written; quo holds until the next division completes.
module apvr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [apvr_pkg::NUM_W-1:0] num,
  input  logic [apvr_pkg::DEN_W-1:0]        den,
  output logic                              busy,
  output logic signed [apvr_pkg::QUO_W-1:0] quo
);
  import apvr_pkg::*;

  logic                     busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]      mag_r, mag_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W:0]           rem_sh;
  logic                     fits;
  logic [NUM_W-1:0]         mag_full;

  always_comb begin
    rem_sh   = {rem_r, mag_r[DIV_BITS-1]};
    fits     = (rem_sh >= {1'b0, den});
    // floor(n/d) for n < 0 is -ceil(-n/d)
    mag_full = num[NUM_W-1] ? (NUM_W'(-num) + NUM_W'(den) - NUM_W'(1)) : NUM_W'(num);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[NUM_W-1];
      mag_nxt  = mag_full[DIV_BITS-1:0];
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == DIV_CNT_W'(DIV_BITS)) begin
        quo_nxt  = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        mag_nxt = {mag_r[DIV_BITS-2:0], fits};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/apvr_dp.sv
// Datapath: error wrap, integral/derivative division, gain multiply-accumulate, clamp.
// Depends on apvr_pkg and apvr_div; driven by apvr_ctrl through cmd_t.
// Holds error_integral and last_error state.
module apvr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  apvr_pkg::cfg_t                    cfg,
  input  logic signed [apvr_pkg::ANG_W-1:0] in_angle,
  input  logic                              in_ovr,
  input  apvr_pkg::cmd_t                    cmd,
  output apvr_pkg::sts_t                    sts,
  output logic signed [apvr_pkg::VEL_W-1:0] vel,
  output logic                              clamp
);
  import apvr_pkg::*;

  logic signed [RAW_W-1:0]   err_r;
  logic                      ovr_r;
  logic                      wpos_r, wneg_r;
  logic [ANG_W-1:0]          wrem_r;
  logic signed [ERR_W-1:0]   errw_r;
  logic signed [NUM_W-1:0]   n1_r, n2_r;
  logic [IDIV_MAG_W-1:0]     imag_r;
  logic                      ineg_r;
  logic [IDIV_PROD_W-1:0]    iprod_r;
  logic signed [QUO_W-1:0]   qi_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   last_r;
  logic signed [PROD_W-1:0]  prod_r;
  mul_sel_t                  psel_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [VEL_W-1:0]   vel_r;
  logic                      clamp_r;

  logic [STEP_W-1:0]         period;
  logic [ANG_W-1:0]          wcmp;
  logic signed [RAW_W-1:0]   wfix;
  logic signed [EP_W-1:0]    ep;
  logic signed [ERR_W:0]     de;
  logic signed [NUM_W-IDIV_PRE-1:0] n1_fl;
  logic signed [QUO_W-1:0]   qi_mag;
  logic signed [QUO_W-1:0]   q_d;
  logic                      busy_d;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   sum;

  assign period = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
  assign wcmp   = TWO_PI_U << cmd.wrap_idx;

  always_comb begin
    if (wpos_r) begin
      wfix = $signed({1'b0, wrem_r}) - PI_R + RAW_W'(1);
    end else if (wneg_r) begin
      wfix = PI_R - RAW_W'(1) - $signed({1'b0, wrem_r});
    end else begin
      wfix = err_r;
    end
  end

  // Numerators: 2*e*T + 1000 over 2000, and 2000*(e - e_prev) + T over 2T
  assign ep = EP_W'(errw_r) * EP_W'($signed({1'b0, period}));
  assign de = (ERR_W + 1)'(errw_r) - (ERR_W + 1)'(last_r);

  // Integral quotient: floor by 16, then magnitude times 1/125 through imag_r, iprod_r and qi_r
  assign n1_fl  = $signed(n1_r[NUM_W-1:IDIV_PRE]);
  assign qi_mag = $signed({{(QUO_W-(IDIV_PROD_W-IDIV_SH)){1'b0}},
                           iprod_r[IDIV_PROD_W-1:IDIV_SH]});

  apvr_div u_div_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (n2_r),
    .den   ({period, 1'b0}),
    .busy  (busy_d),
    .quo   (q_d)
  );

  assign sts.div_busy = busy_d;

  // Saturating integral update
  always_comb begin
    isum = (INTEG_W + 1)'(integ_r) + (INTEG_W + 1)'(qi_r);
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_nxt = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  // Shared gain multiplier; integral term is split into two partial products
  always_comb begin
    case (cmd.mul_sel)
      MS_P: begin
        mul_a = $signed({1'b0, cfg.kp});
        mul_b = MUL_B_W'(errw_r);
      end
      MS_D: begin
        mul_a = $signed({1'b0, cfg.kd});
        mul_b = q_d;
      end
      MS_IL: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = $signed({{(MUL_B_W-INTEG_SPLIT){1'b0}}, integ_r[INTEG_SPLIT-1:0]});
      end
      MS_IH: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = MUL_B_W'($signed(integ_r[INTEG_W-1:INTEG_SPLIT]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // High partial product is a multiple of 2^FRAC_BITS, so each term floors on its own
  assign term = (psel_r == MS_IH) ? ACC_W'(prod_r <<< (INTEG_SPLIT - FRAC_BITS))
                                  : ACC_W'(prod_r >>> FRAC_BITS);

  assign sum = ovr_r ? LIMIT : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.out_load) begin
        last_r <= errw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      err_r <= RAW_W'(cfg.tgt) - RAW_W'(in_angle);
      ovr_r <= in_ovr;
    end
    if (cmd.wrap_init) begin
      wpos_r <= (err_r > PI_R);
      wneg_r <= (err_r < -PI_R);
      if (err_r > PI_R) begin
        wrem_r <= ANG_W'(err_r - PI_R - RAW_W'(1));
      end else begin
        wrem_r <= ANG_W'(-PI_R - RAW_W'(1) - err_r);
      end
    end
    if (cmd.wrap_step && (wrem_r >= wcmp)) begin
      wrem_r <= wrem_r - wcmp;
    end
    if (cmd.wrap_fin) begin
      errw_r <= ERR_W'(wfix);
    end
    if (cmd.prep) begin
      n1_r <= (NUM_W'(ep) <<< 1) + NUM_W'(MS_PER_S);
      n2_r <= NUM_W'(de) * NUM_W'(2 * MS_PER_S) + $signed({{(NUM_W-STEP_W){1'b0}}, period});
    end
    // floor(m/125) for m < 0 is -floor((-m + 124)/125)
    if (cmd.div_start) begin
      ineg_r <= n1_fl[NUM_W-IDIV_PRE-1];
      if (n1_fl[NUM_W-IDIV_PRE-1]) begin
        imag_r <= IDIV_MAG_W'(-n1_fl + (NUM_W-IDIV_PRE)'(IDIV_ODD - 1));
      end else begin
        imag_r <= IDIV_MAG_W'(n1_fl);
      end
    end
    iprod_r <= IDIV_PROD_W'(imag_r) * IDIV_PROD_W'(IDIV_RECIP);
    qi_r    <= ineg_r ? -qi_mag : qi_mag;
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      psel_r <= cmd.mul_sel;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + term;
    end
    if (cmd.out_load) begin
      clamp_r <= (sum > LIMIT) || (sum < -LIMIT);
      if (sum > LIMIT) begin
        vel_r <= VEL_W'(LIMIT);
      end else if (sum < -LIMIT) begin
        vel_r <= VEL_W'(-LIMIT);
      end else begin
        vel_r <= VEL_W'(sum);
      end
    end
  end

  assign vel   = vel_r;
  assign clamp = clamp_r;

endmodule

FILE: rtl/apvr_ctrl.sv
// Sequencer for one control tick: wrap, divide, multiply-accumulate, output.
// Depends on apvr_pkg; commands apvr_dp through cmd_t, reads sts_t.
// Owns the input ready and the output valid flag.
module apvr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  apvr_pkg::sts_t sts,
  output apvr_pkg::cmd_t cmd
);
  import apvr_pkg::*;

  state_t                state_r, state_nxt;
  logic [WRAP_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                  oval_r, oval_nxt;
  logic                  out_free;

  assign out_free = !oval_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WINIT;
        end
      end
      ST_WINIT: begin
        state_nxt = ST_WSTEP;
        cnt_nxt   = WRAP_IDX_W'(WRAP_STEPS - 1);
      end
      ST_WSTEP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_WFIN;
        end else begin
          cnt_nxt = cnt_r - WRAP_IDX_W'(1);
        end
      end
      ST_WFIN:   state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_MP;
        end
      end
      ST_MP:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_MIL;
      ST_MIL:  state_nxt = ST_MIH;
      ST_MIH:  state_nxt = ST_MACC;
      ST_MACC: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MS_P;
    cmd.wrap_idx = cnt_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_err = in_valid;
      end
      ST_WINIT:  cmd.wrap_init = 1'b1;
      ST_WSTEP:  cmd.wrap_step = 1'b1;
      ST_WFIN:   cmd.wrap_fin  = 1'b1;
      ST_PREP:   cmd.prep      = 1'b1;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DWAIT: ;
      ST_MP: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MS_P;
        cmd.acc_clr   = 1'b1;
      end
      ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_D;
        cmd.acc_en  = 1'b1;
      end
      ST_MIL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_IL;
        cmd.acc_en  = 1'b1;
      end
      ST_MIH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_IH;
        cmd.acc_en  = 1'b1;
      end
      ST_MACC:  cmd.acc_en   = 1'b1;
      ST_FIN:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

endmodule

FILE: rtl/angle_pid_velocity_regulator_core.sv
// Top level of the angle PID velocity regulator: config registers, controller, datapath.
// Depends on apvr_pkg, apvr_ctrl, apvr_dp (and apvr_div below it).
//
// Usage:
//  - Input stream (in_*): one item per control tick. in_tdata carries the measured
//    shaft angle (signed Q8.16), in_tuser the manual-override flag.
//  - Output stream (out_*): one item per input item, the clamped velocity command
//    (signed Q5.16, within +/-10) and a flag telling whether the clamp cut the sum.
//  - Config port (cfg_*): register index plus data, always ready. Write only while
//    the block is idle. Index 0 Kp, 1 Ki, 2 Kd, 3 setpoint, 4 step_ms; others ignored.
//  - An input goes through the wrap reduction, the bit-serial divider for the
//    derivative (scaling by 1/dt) and four shared multiplier passes before out_tvalid;
//    no new input is taken until then. The integral's division by 1000 is a reciprocal
//    multiply that finishes while the divider runs.
//  - The result sits in an output register; a new input is taken while it waits.
//    If the receiver stalls, the next item holds in its final state until the
//    output register frees up.
//  - Reset (synchronous, rst_n low) restores the register defaults, clears the error
//    integral and the previous error, and empties the output register.
module angle_pid_velocity_regulator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [23:0] measured_angle
  input  logic [23:0]                        in_tdata,
  // in_tuser: [0] force_override
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: [20:0] drive_velocity, [23:21] zero
  output logic [23:0]                        out_tdata,
  // out_tuser: [0] was_clamped
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apvr_pkg::ANG_W-1:0]         cfg_data
);
  import apvr_pkg::*;

  cfg_t                    cfg_r, cfg_nxt;
  cmd_t                    cmd;
  sts_t                    sts;
  logic signed [VEL_W-1:0] vel;
  logic                    clamp;

  assign cfg_ready = 1'b1;

  // Register file write; unknown indexes leave everything as is
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_KP:   cfg_nxt.kp   = cfg_data;
        REG_KI:   cfg_nxt.ki   = cfg_data;
        REG_KD:   cfg_nxt.kd   = cfg_data;
        REG_TGT:  cfg_nxt.tgt  = $signed(cfg_data);
        REG_STEP: cfg_nxt.step = cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp   <= RST_KP;
      cfg_r.ki   <= RST_KI;
      cfg_r.kd   <= RST_KD;
      cfg_r.tgt  <= $signed(RST_TGT);
      cfg_r.step <= RST_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apvr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_angle ($signed(in_tdata)),
    .in_ovr   (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .vel      (vel),
    .clamp    (clamp)
  );

  assign out_tdata = {{(24-VEL_W){1'b0}}, vel};
  assign out_tuser = clamp;

endmodule
